### src/assert_macros.svh
// Assertion shorthands used by the checker file.
// Each macro samples on the rising edge of clk and is held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### src/ccbv_pkg.sv
package ccbv_pkg;

	// Field widths fixed by the interface
	localparam int COORD_W    = 9;
	localparam int ORIENT_W   = 4;
	localparam int DIM_W      = 3;
	localparam int EXT_W      = 5;
	localparam int INDEX_W    = 31;
	localparam int IO_VALUE_W = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ORIENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_DIM    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd3;

	// Request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Orientation codes
	localparam logic [ORIENT_W-1:0] ORI_A = 4'd0;
	localparam logic [ORIENT_W-1:0] ORI_B = 4'd1;
	localparam logic [ORIENT_W-1:0] ORI_C = 4'd2;

	// Cell dimensions
	localparam logic [DIM_W-1:0] DIM_VERTEX = 3'd0;
	localparam logic [DIM_W-1:0] DIM_EDGE   = 3'd1;
	localparam logic [DIM_W-1:0] DIM_SQUARE = 3'd2;
	localparam logic [DIM_W-1:0] DIM_CUBE   = 3'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BORDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_X  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_Y  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_Z  = 2'd3;

	localparam logic [EXT_W-1:0] EXTENT_RESET = 5'd30;

	// Decoded cell: status and span along each axis
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                dx;
		logic                dy;
		logic                dz;
	} ccbv_cell_t;

	// Control of the shared compare unit
	typedef struct packed {
		logic start;
		logic preset;
		logic cmp;
	} ccbv_max_ctl_t;

endpackage

### src/cubical_cell_birth_value.sv
// Birth value of a cell in a 3D cubical complex. The block keeps a voxel grid of
// GRID_SIDE^3 signed fixed-point words in one single-port memory, addressed as {z, y, x}.
// A load item writes one voxel; a query item returns the signed maximum over the 1, 2, 4
// or 8 corner voxels of the named cell, with padding voxels (coordinate 0 or beyond the
// configured extent) reading as border_value. Bad dimension, bad orientation and
// out-of-grid cells return border_value with a status code; an out-of-grid load writes
// nothing. One item is in flight at a time: a load or a rejected query steps from idle
// through check and finish, a good query through check, read, drain and finish, with the
// one memory read port fetching one corner a cycle in read into a single shared
// compare unit. The result sits in an output register, so the next item is accepted
// while it waits; that item only stalls at its own result if the previous one is still
// untaken. Voxel contents are undefined until written; there is no clearing pass.
// Configuration writes are taken in any cycle (cfg_ready is always high).
module cubical_cell_birth_value #(
	parameter int GRID_SIDE  = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ccbv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ccbv_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request channel
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic                               req_type,
	input  logic [ccbv_pkg::INDEX_W-1:0]       cell_index,
	input  logic [ccbv_pkg::DIM_W-1:0]         cell_dim,
	input  logic signed [ccbv_pkg::IO_VALUE_W-1:0] load_value,
	// response channel
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic signed [ccbv_pkg::IO_VALUE_W-1:0] birth_value,
	output logic [ccbv_pkg::STATUS_W-1:0]      result_status
);
	import ccbv_pkg::*;

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [VALUE_BITS-1:0] border_q;
	logic [EXT_W-1:0]             ext_x_q, ext_y_q, ext_z_q;

	// captured request
	logic                         req_type_q;
	logic [COORD_W-1:0]           cx_q, cy_q, cz_q;
	logic [ORIENT_W-1:0]          orient_q;
	logic [DIM_W-1:0]             dim_q;
	logic signed [VALUE_BITS-1:0] load_q;

	// corner walk
	logic [2:0]                   cnt_q;
	logic [2:0]                   span_mask;
	logic [2:0]                   cnt_next;
	logic                         last_corner;
	logic [COORD_W-1:0]           kx, ky, kz;
	logic                         pad;
	logic                         rd_s1;
	logic                         pad_s1;

	// response registers
	logic                         rsp_valid_q;
	logic signed [IO_VALUE_W-1:0] birth_q;
	logic [STATUS_W-1:0]          status_q;

	ccbv_cell_t                   shape;
	ccbv_max_ctl_t                max_ctl;
	logic                         ram_we;
	logic [AW-1:0]                ram_addr;
	logic [VALUE_BITS-1:0]        ram_rdata;
	logic signed [VALUE_BITS-1:0] sample;
	logic signed [VALUE_BITS-1:0] preset_value;
	logic signed [VALUE_BITS-1:0] best;
	logic                         query_ok;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);

	// Configuration: wrap the border value to the storage width, keep the low extent bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q <= '0;
			ext_x_q  <= EXTENT_RESET;
			ext_y_q  <= EXTENT_RESET;
			ext_z_q  <= EXTENT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BORDER: border_q <= VALUE_BITS'($signed(cfg_data));
				REG_EXT_X:  ext_x_q  <= cfg_data[EXT_W-1:0];
				REG_EXT_Y:  ext_y_q  <= cfg_data[EXT_W-1:0];
				REG_EXT_Z:  ext_z_q  <= cfg_data[EXT_W-1:0];
				default:    ext_z_q  <= ext_z_q;
			endcase
		end
	end

	// Hold the accepted item for the whole of its processing
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_type_q <= req_type;
			cx_q       <= cell_index[COORD_W-1:0];
			cy_q       <= cell_index[2*COORD_W-1:COORD_W];
			cz_q       <= cell_index[3*COORD_W-1:2*COORD_W];
			orient_q   <= cell_index[3*COORD_W+ORIENT_W-1:3*COORD_W];
			dim_q      <= cell_dim;
			load_q     <= VALUE_BITS'(load_value);
		end
	end

	ccbv_decode #(
		.GRID_SIDE(GRID_SIDE)
	) u_decode (
		.req_type(req_type_q),
		.cx      (cx_q),
		.cy      (cy_q),
		.cz      (cz_q),
		.orient  (orient_q),
		.dim     (dim_q),
		.shape   (shape)
	);

	assign query_ok = (req_type_q == REQ_QUERY) && (shape.status == ST_OK);

	// Step the corner counter through the subsets of the cell's spanned axes;
	// the walk ends when the next subset wraps to zero.
	assign span_mask   = {shape.dz, shape.dy, shape.dx};
	assign cnt_next    = ((cnt_q | ~span_mask) + 3'd1) & span_mask;
	assign last_corner = (cnt_next == 3'd0);

	assign kx = cx_q + COORD_W'(cnt_q[0]);
	assign ky = cy_q + COORD_W'(cnt_q[1]);
	assign kz = cz_q + COORD_W'(cnt_q[2]);

	// Padding voxel: coordinate zero or past the extent on any axis
	assign pad = (kx == '0) || (kx > COORD_W'(ext_x_q)) ||
	             (ky == '0) || (ky > COORD_W'(ext_y_q)) ||
	             (kz == '0) || (kz > COORD_W'(ext_z_q));

	// The counter is zero during the check state, so a load addresses its own voxel
	assign ram_we   = (state_q == S_CHECK) && (req_type_q == REQ_LOAD) && (shape.status == ST_OK);
	assign ram_addr = {kz[CW-1:0], ky[CW-1:0], kx[CW-1:0]};

	ccbv_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_voxels (
		.clk    (clk),
		.we     (ram_we),
		.addr   (ram_addr),
		.wdata  (load_q),
		.rdata_q(ram_rdata)
	);

	// Shared compare unit: preset for loads and rejected queries, otherwise
	// fold in one corner per cycle as the read data arrives
	assign sample       = pad_s1 ? border_q : $signed(ram_rdata);
	assign preset_value = (req_type_q == REQ_LOAD) ? '0 : border_q;

	always_comb begin
		max_ctl        = '0;
		max_ctl.start  = (state_q == S_CHECK) && query_ok;
		max_ctl.preset = (state_q == S_CHECK) && !query_ok;
		max_ctl.cmp    = rd_s1;
	end

	ccbv_max #(
		.WIDTH(VALUE_BITS)
	) u_max (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (max_ctl),
		.preset_value(preset_value),
		.sample      (sample),
		.best        (best)
	);

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			pad_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
			birth_q     <= '0;
			status_q    <= ST_OK;
		end else begin
			rd_s1  <= (state_q == S_READ);
			pad_s1 <= pad;
			// hold valid while a result is loaded, drop it once taken
			if (state_q == S_FINISH && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= query_ok ? S_READ : S_FINISH;
				end
				S_READ: begin
					cnt_q <= cnt_next;
					if (last_corner) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last corner is folded in this cycle
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// drop the result into the output register once it is free
					if (!rsp_valid_q || rsp_ready) begin
						birth_q  <= IO_VALUE_W'(best);
						status_q <= shape.status;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign birth_value   = birth_q;
	assign result_status = status_q;

endmodule

### src/ccbv_ram.sv
module ccbv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port: a write cycle does not update the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

endmodule

### src/ccbv_decode.sv
module ccbv_decode #(
	parameter int GRID_SIDE = 32
) (
	input  logic                          req_type,
	input  logic [ccbv_pkg::COORD_W-1:0]  cx,
	input  logic [ccbv_pkg::COORD_W-1:0]  cy,
	input  logic [ccbv_pkg::COORD_W-1:0]  cz,
	input  logic [ccbv_pkg::ORIENT_W-1:0] orient,
	input  logic [ccbv_pkg::DIM_W-1:0]    dim,
	output ccbv_pkg::ccbv_cell_t          shape
);
	import ccbv_pkg::*;

	localparam int LIM_W = COORD_W + 1;
	localparam logic [LIM_W-1:0] LIMIT = LIM_W'(GRID_SIDE);

	logic [LIM_W-1:0] ex, ey, ez;

	always_comb begin
		shape = '0;
		if (req_type == REQ_QUERY) begin
			case (dim)
				DIM_VERTEX: begin
					shape.status = ST_OK;
				end
				DIM_EDGE: begin
					case (orient)
						ORI_A:   shape.dx = 1'b1;
						ORI_B:   shape.dy = 1'b1;
						ORI_C:   shape.dz = 1'b1;
						default: shape.status = ST_BAD_ORIENT;
					endcase
				end
				DIM_SQUARE: begin
					case (orient)
						ORI_A: begin
							shape.dx = 1'b1;
							shape.dy = 1'b1;
						end
						ORI_B: begin
							shape.dz = 1'b1;
							shape.dx = 1'b1;
						end
						ORI_C: begin
							shape.dy = 1'b1;
							shape.dz = 1'b1;
						end
						default: shape.status = ST_BAD_ORIENT;
					endcase
				end
				DIM_CUBE: begin
					shape.dx = 1'b1;
					shape.dy = 1'b1;
					shape.dz = 1'b1;
				end
				default: shape.status = ST_BAD_DIM;
			endcase
		end
		// far corner must stay inside the grid (spans are zero for loads)
		ex = {1'b0, cx} + LIM_W'(shape.dx);
		ey = {1'b0, cy} + LIM_W'(shape.dy);
		ez = {1'b0, cz} + LIM_W'(shape.dz);
		if (shape.status == ST_OK && (ex >= LIMIT || ey >= LIMIT || ez >= LIMIT)) begin
			shape.status = ST_RANGE;
		end
	end

endmodule

### src/ccbv_max.sv
module ccbv_max #(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ccbv_pkg::ccbv_max_ctl_t ctl,
	input  logic signed [WIDTH-1:0] preset_value,
	input  logic signed [WIDTH-1:0] sample,
	output logic signed [WIDTH-1:0] best
);
	import ccbv_pkg::*;

	logic                    first_q;
	logic signed [WIDTH-1:0] best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (ctl.preset) begin
			first_q <= 1'b0;
		end else if (ctl.start) begin
			first_q <= 1'b1;
		end else if (ctl.cmp) begin
			first_q <= 1'b0;
		end
	end

	// Take the first sample unconditionally, then keep the signed maximum
	always_ff @(posedge clk) begin
		if (ctl.preset) begin
			best_q <= preset_value;
		end else if (ctl.cmp && (first_q || sample > best_q)) begin
			best_q <= sample;
		end
	end

	assign best = best_q;

endmodule

### src/ccbv_checker.sv
`include "assert_macros.svh"

module ccbv_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready,
	input logic [ccbv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input logic [ccbv_pkg::CFG_DATA_W-1:0]        cfg_data,
	input logic                                   req_valid,
	input logic                                   req_ready,
	input logic                                   rsp_valid,
	input logic                                   rsp_ready,
	input logic signed [ccbv_pkg::IO_VALUE_W-1:0] birth_value,
	input logic [ccbv_pkg::STATUS_W-1:0]          result_status
);
	import ccbv_pkg::*;

	logic signed [VALUE_BITS-1:0] border_w;
	logic signed [IO_VALUE_W-1:0] border_mirror_q;

	// Track the border value as the port writes it
	assign border_w = VALUE_BITS'($signed(cfg_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_mirror_q <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index == REG_BORDER) begin
			border_mirror_q <= IO_VALUE_W'(border_w);
		end
	end

	`ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(birth_value) && $stable(result_status))
	`ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready ##1 !req_ready)
	`ASSERT_SAME(a_error_border, rsp_valid && (result_status == ST_BAD_ORIENT || result_status == ST_BAD_DIM), birth_value == border_mirror_q)

endmodule

bind cubical_cell_birth_value ccbv_checker #(.VALUE_BITS(VALUE_BITS)) u_ccbv_checker (.*);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import ccbv_pkg::*;

	// Grid geometry, matched to the instance below
	localparam int GRID      = 32;
	localparam int GRID_MAX  = 511;   // largest coordinate a 9-bit field can carry

	// Orientation and dimension values that lie outside the legal codes
	localparam logic [ORIENT_W-1:0] ORI_BAD_LOW = 4'd3;
	localparam logic [ORIENT_W-1:0] ORI_BAD_TOP = 4'd15;
	localparam logic [DIM_W-1:0]    DIM_BAD_LOW = 3'd4;
	localparam logic [DIM_W-1:0]    DIM_BAD_TOP = 3'd7;

	// Q16.16 extremes
	localparam logic signed [IO_VALUE_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [IO_VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

	localparam int PHASE_ITEMS  = 400;      // random items per traffic phase
	localparam int DRAIN_LIMIT  = 4000;     // cycles allowed for outstanding results
	localparam int TAIL_CYCLES  = 16;       // quiet cycles once nothing is outstanding
	localparam int HOLDOFF_LEN  = 250;      // long receiver stall for the pressure test
	localparam int RUN_LIMIT_NS = 8_000_000;

	typedef enum logic [1:0] {RX_EAGER, RX_RANDOM, RX_PATTERN} rx_style_t;

	// One expected result of the block
	typedef struct packed {
		logic [IO_VALUE_W-1:0] value;
		logic [STATUS_W-1:0]   status;
	} birth_result_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           cfg_valid  = 1'b0;
	logic                           cfg_ready;
	logic [CFG_IDX_W-1:0]           cfg_index  = '0;
	logic [CFG_DATA_W-1:0]          cfg_data   = '0;
	logic                           req_valid  = 1'b0;
	logic                           req_ready;
	logic                           req_type   = REQ_LOAD;
	logic [INDEX_W-1:0]             cell_index = '0;
	logic [DIM_W-1:0]               cell_dim   = '0;
	logic signed [IO_VALUE_W-1:0]   load_value = '0;
	logic                           rsp_valid;
	logic                           rsp_ready  = 1'b0;
	logic signed [IO_VALUE_W-1:0]   birth_value;
	logic [STATUS_W-1:0]            result_status;

	// Shadow of the configuration, starting from the reset values
	logic signed [IO_VALUE_W-1:0]   border_q = '0;
	logic [EXT_W-1:0]               ext_x    = EXTENT_RESET;
	logic [EXT_W-1:0]               ext_y    = EXTENT_RESET;
	logic [EXT_W-1:0]               ext_z    = EXTENT_RESET;

	// Shadow of the voxel grid; voxel_written guards against reading unknown words
	logic signed [IO_VALUE_W-1:0]   voxel_mem     [0:GRID*GRID*GRID-1];
	bit                             voxel_written [0:GRID*GRID*GRID-1];

	birth_result_t                  birth_expected[$];
	birth_result_t                  got_want;

	int                             mismatches   = 0;
	int                             results_seen = 0;
	int                             items_sent   = 0;
	int                             burst_left   = 0;
	bit                             sender_gaps  = 1'b0;
	rx_style_t                      rx_style     = RX_EAGER;
	int unsigned                    holdoff_cycles = 0;
	int                             rx_step      = 0;
	logic [15:0]                    rx_pattern   = 16'b1110_1101_0011_1011;

	cubical_cell_birth_value #(
		.GRID_SIDE  (GRID),
		.VALUE_BITS (32)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_type      (req_type),
		.cell_index    (cell_index),
		.cell_dim      (cell_dim),
		.load_value    (load_value),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.birth_value   (birth_value),
		.result_status (result_status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int addr_of(int x, int y, int z);
		return x + GRID * (y + GRID * z);
	endfunction

	// Interior voxels sit at 1..extent on every axis; everything else is padding
	function automatic bit is_interior(int x, int y, int z);
		return x >= 1 && x <= int'(ext_x) && x < GRID &&
		       y >= 1 && y <= int'(ext_y) && y < GRID &&
		       z >= 1 && z <= int'(ext_z) && z < GRID;
	endfunction

	// Decode dimension and orientation into a span per axis, then check the far
	// corner against the grid. Bad dimension wins over bad orientation, and both
	// win over the range check.
	function automatic ccbv_cell_t shape_of(logic [INDEX_W-1:0] idx, logic [DIM_W-1:0] dim);
		ccbv_cell_t          c;
		logic [ORIENT_W-1:0] ori;
		ori      = idx[30:27];
		c        = '0;
		c.status = ST_OK;
		if (dim > DIM_CUBE) begin
			c.status = ST_BAD_DIM;
		end else if (dim == DIM_EDGE) begin
			case (ori)
				ORI_A:   c.dx = 1'b1;
				ORI_B:   c.dy = 1'b1;
				ORI_C:   c.dz = 1'b1;
				default: c.status = ST_BAD_ORIENT;
			endcase
		end else if (dim == DIM_SQUARE) begin
			case (ori)
				ORI_A:   begin c.dx = 1'b1; c.dy = 1'b1; end
				ORI_B:   begin c.dz = 1'b1; c.dx = 1'b1; end
				ORI_C:   begin c.dy = 1'b1; c.dz = 1'b1; end
				default: c.status = ST_BAD_ORIENT;
			endcase
		end else if (dim == DIM_CUBE) begin
			c.dx = 1'b1;
			c.dy = 1'b1;
			c.dz = 1'b1;
		end
		if (c.status == ST_OK &&
		    (int'(idx[8:0]) + int'(c.dx) >= GRID || int'(idx[17:9]) + int'(c.dy) >= GRID ||
		     int'(idx[26:18]) + int'(c.dz) >= GRID))
			c.status = ST_RANGE;
		return c;
	endfunction

	// Work out the result of one accepted item and apply a load to the shadow grid
	function automatic birth_result_t predict_birth(logic kind, logic [INDEX_W-1:0] idx,
			logic [DIM_W-1:0] dim, logic signed [IO_VALUE_W-1:0] val);
		birth_result_t                r;
		ccbv_cell_t                   c;
		logic signed [IO_VALUE_W-1:0] best;
		logic signed [IO_VALUE_W-1:0] v;
		bit                           first;
		int                           x, y, z, i, j, k;
		x = int'(idx[8:0]);
		y = int'(idx[17:9]);
		z = int'(idx[26:18]);
		if (kind == REQ_LOAD) begin
			r.value = '0;
			if (x >= GRID || y >= GRID || z >= GRID) begin
				r.status = ST_RANGE;
			end else begin
				voxel_mem[addr_of(x, y, z)]     = val;
				voxel_written[addr_of(x, y, z)] = 1'b1;
				r.status = ST_OK;
			end
			return r;
		end
		c     = shape_of(idx, dim);
		best  = border_q;
		first = 1'b1;
		if (c.status == ST_OK) begin
			for (k = 0; k <= int'(c.dz); k++)
				for (j = 0; j <= int'(c.dy); j++)
					for (i = 0; i <= int'(c.dx); i++) begin
						v = is_interior(x + i, y + j, z + k) ?
						    voxel_mem[addr_of(x + i, y + j, z + k)] : border_q;
						if (first || v > best)
							best = v;
						first = 1'b0;
					end
		end
		r.value  = best;
		r.status = c.status;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Compare every taken result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (birth_expected.size() == 0) begin
				flag_mismatch($sformatf("result %0d with nothing expected: value %h status %0d",
					results_seen, birth_value, result_status));
			end else begin
				got_want = birth_expected.pop_front();
				if (birth_value !== got_want.value || result_status !== got_want.status)
					flag_mismatch($sformatf(
						"result %0d: expected value %h status %0d, got value %h status %0d",
						results_seen, got_want.value, got_want.status,
						birth_value, result_status));
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stalls on a style of its own, or holds off for a counted stretch
	// ------------------------------------------------------------------

	always begin
		@(negedge clk);
		if (holdoff_cycles != 0) begin
			rsp_ready <= 1'b0;
			repeat (holdoff_cycles) @(negedge clk);
			holdoff_cycles = 0;
		end else begin
			case (rx_style)
				RX_EAGER:  rsp_ready <= 1'b1;
				RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
				default: begin
					rsp_ready <= rx_pattern[rx_step % 16];
					rx_step++;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------

	// Offer one item and hold it until taken; between bursts, drop valid for a gap
	task automatic drive_item(logic kind, logic [INDEX_W-1:0] idx, logic [DIM_W-1:0] dim,
			logic signed [IO_VALUE_W-1:0] val);
		if (sender_gaps && burst_left == 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end else begin
			@(negedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		req_valid  <= 1'b1;
		req_type   <= kind;
		cell_index <= idx;
		cell_dim   <= dim;
		load_value <= val;
		do @(posedge clk); while (!req_ready);
		birth_expected.push_back(predict_birth(kind, idx, dim, val));
		items_sent++;
	endtask

	// Send one item. Before a query, load any interior corner that has never been
	// written, so that the block is never asked for an unknown word.
	task automatic send_item(logic kind, logic [INDEX_W-1:0] idx, logic [DIM_W-1:0] dim,
			logic signed [IO_VALUE_W-1:0] val);
		ccbv_cell_t         c;
		logic [INDEX_W-1:0] fill_idx;
		int                 x, y, z, i, j, k;
		if (kind == REQ_QUERY) begin
			c = shape_of(idx, dim);
			if (c.status == ST_OK) begin
				for (k = 0; k <= int'(c.dz); k++)
					for (j = 0; j <= int'(c.dy); j++)
						for (i = 0; i <= int'(c.dx); i++) begin
							x = int'(idx[8:0]) + i;
							y = int'(idx[17:9]) + j;
							z = int'(idx[26:18]) + k;
							if (is_interior(x, y, z) && !voxel_written[addr_of(x, y, z)]) begin
								fill_idx = cell_at(x, y, z, ORI_A);
								fill_idx[30:27] = ORIENT_W'($urandom);
								drive_item(REQ_LOAD, fill_idx, DIM_W'($urandom), pick_value());
							end
						end
			end
		end
		drive_item(kind, idx, dim, val);
	endtask

	// Drop valid, wait for every outstanding result, then let the block go quiet
	task automatic settle();
		int waited;
		@(negedge clk);
		req_valid <= 1'b0;
		waited = 0;
		while (birth_expected.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (birth_expected.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", birth_expected.size()));
			birth_expected.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_BORDER: border_q = data;
			REG_EXT_X:  ext_x    = data[EXT_W-1:0];
			REG_EXT_Y:  ext_y    = data[EXT_W-1:0];
			default:    ext_z    = data[EXT_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Extent writes carry random upper bits, which the block must ignore
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [EXT_W-1:0] ext);
		logic [CFG_DATA_W-1:0] d;
		d            = $urandom;
		d[EXT_W-1:0] = ext;
		return d;
	endfunction

	// Write all four registers once the block is idle
	task automatic configure(logic signed [IO_VALUE_W-1:0] border, int ex, int ey, int ez);
		settle();
		write_reg(REG_BORDER, border);
		write_reg(REG_EXT_X, with_junk(EXT_W'(ex)));
		write_reg(REG_EXT_Y, with_junk(EXT_W'(ey)));
		write_reg(REG_EXT_Z, with_junk(EXT_W'(ez)));
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [INDEX_W-1:0] cell_at(int x, int y, int z,
			logic [ORIENT_W-1:0] ori);
		logic [INDEX_W-1:0] idx;
		idx        = '0;
		idx[8:0]   = COORD_W'(x);
		idx[17:9]  = COORD_W'(y);
		idx[26:18] = COORD_W'(z);
		idx[30:27] = ori;
		return idx;
	endfunction

	// Favour the low corner and the far edge of the interior, so voxels get reused
	function automatic logic [COORD_W-1:0] pick_coord(logic [EXT_W-1:0] ext);
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return COORD_W'($urandom_range(0, 4));
		if (r < 80)
			return COORD_W'($urandom_range(ext < 2 ? 0 : int'(ext) - 2, int'(ext) + 1));
		if (r < 95)
			return COORD_W'($urandom_range(0, GRID - 1));
		return COORD_W'($urandom_range(GRID, GRID_MAX));
	endfunction

	function automatic logic signed [IO_VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2:       return 32'($urandom_range(0, 6)) - 32'd3;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed loads and queries near the interior; the rest is noise
	task automatic random_item();
		logic               kind;
		logic [INDEX_W-1:0] idx;
		logic [DIM_W-1:0]   dim;
		if ($urandom_range(0, 99) < 80) begin
			kind       = ($urandom_range(0, 99) < 35) ? REQ_LOAD : REQ_QUERY;
			idx[8:0]   = pick_coord(ext_x);
			idx[17:9]  = pick_coord(ext_y);
			idx[26:18] = pick_coord(ext_z);
			if (kind == REQ_QUERY) begin
				idx[30:27] = ORIENT_W'($urandom_range(ORI_A, ORI_C));
				dim        = DIM_W'($urandom_range(DIM_VERTEX, DIM_CUBE));
			end else begin
				idx[30:27] = ORIENT_W'($urandom);
				dim        = DIM_W'($urandom);
			end
		end else begin
			kind = 1'($urandom_range(0, 1));
			idx  = INDEX_W'($urandom);
			dim  = DIM_W'($urandom);
		end
		send_item(kind, idx, dim, pick_value());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Loads at the corners of the grid, into padding, and past its edge
	task automatic test_load_extremes();
		sender_gaps = 1'b0;
		rx_style    = RX_EAGER;
		send_item(REQ_LOAD, cell_at(1, 1, 1, ORI_A), DIM_VERTEX, Q_MAX);
		send_item(REQ_LOAD, cell_at(30, 30, 30, ORI_BAD_TOP), DIM_BAD_TOP, Q_MIN);
		send_item(REQ_LOAD, cell_at(31, 31, 31, ORI_A), DIM_VERTEX, 32'sd5);
		send_item(REQ_LOAD, cell_at(GRID, 5, 5, ORI_A), DIM_VERTEX, -32'sd1);
		send_item(REQ_LOAD, cell_at(GRID_MAX, GRID_MAX, GRID_MAX, ORI_BAD_TOP), DIM_CUBE,
			-32'sd1);
	endtask

	// Every dimension and every orientation, at reset configuration
	task automatic test_cell_shapes();
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_A), DIM_VERTEX, '0);
		send_item(REQ_QUERY, cell_at(31, 31, 31, ORI_A), DIM_VERTEX, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_A), DIM_EDGE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_B), DIM_EDGE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_C), DIM_EDGE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_A), DIM_SQUARE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_B), DIM_SQUARE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_C), DIM_SQUARE, '0);
		send_item(REQ_QUERY, cell_at(0, 0, 0, ORI_A), DIM_CUBE, '0);
		send_item(REQ_QUERY, cell_at(30, 30, 30, ORI_A), DIM_CUBE, '0);
	endtask

	// Bad dimension, bad orientation, ignored orientation and cells off the grid
	task automatic test_error_cases();
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_BAD_LOW), DIM_BAD_LOW, '0);
		send_item(REQ_QUERY, cell_at(GRID_MAX, 1, 1, ORI_A), DIM_BAD_TOP, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_BAD_LOW), DIM_EDGE, '0);
		send_item(REQ_QUERY, cell_at(31, 1, 1, ORI_BAD_TOP), DIM_SQUARE, '0);
		send_item(REQ_QUERY, cell_at(30, 30, 30, ORI_BAD_TOP), DIM_VERTEX, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_BAD_LOW), DIM_CUBE, '0);
		send_item(REQ_QUERY, cell_at(31, 1, 1, ORI_A), DIM_CUBE, '0);
		send_item(REQ_QUERY, cell_at(1, 31, 1, ORI_B), DIM_EDGE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 31, ORI_C), DIM_SQUARE, '0);
		send_item(REQ_QUERY, cell_at(5, 5, 40, ORI_A), DIM_VERTEX, '0);
	endtask

	// Border at both extremes with extents of 1 and of 30, then a random border with mixed extents
	task automatic test_config_extremes();
		configure(Q_MAX, 1, 1, 1);
		send_item(REQ_QUERY, cell_at(0, 0, 0, ORI_A), DIM_CUBE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_A), DIM_VERTEX, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 1, ORI_B), DIM_EDGE, '0);
		configure(Q_MIN, 30, 30, 30);
		send_item(REQ_QUERY, cell_at(0, 0, 0, ORI_A), DIM_CUBE, '0);
		send_item(REQ_QUERY, cell_at(0, 0, 0, ORI_A), DIM_VERTEX, '0);
		send_item(REQ_QUERY, cell_at(30, 30, 30, ORI_C), DIM_SQUARE, '0);
		configure($urandom, 30, 1, 17);
		send_item(REQ_QUERY, cell_at(29, 0, 16, ORI_A), DIM_CUBE, '0);
		send_item(REQ_QUERY, cell_at(1, 1, 17, ORI_C), DIM_EDGE, '0);
		send_item(REQ_QUERY, cell_at(30, 1, 17, ORI_A), DIM_VERTEX, '0);
	endtask

	// Hold the receiver off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		int n;
		settle();
		sender_gaps    = 1'b0;
		rx_style       = RX_EAGER;
		holdoff_cycles = HOLDOFF_LEN;
		for (n = 0; n < 40; n++)
			random_item();
		settle();
	endtask

	// Long random runs under several configurations and idling styles
	task automatic test_random_traffic();
		int phase;
		int stop_at;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					configure($urandom, 30, 30, 30);
					sender_gaps = 1'b1;
					rx_style    = RX_RANDOM;
				end
				1: begin
					configure(Q_MAX, 1, 1, 1);
					sender_gaps = 1'b0;
					rx_style    = RX_PATTERN;
				end
				2: begin
					configure(Q_MIN, $urandom_range(1, 30), $urandom_range(1, 30),
						$urandom_range(1, 30));
					sender_gaps = 1'b1;
					rx_style    = RX_EAGER;
				end
				default: begin
					configure($urandom, 30, 1, 17);
					sender_gaps = 1'b1;
					rx_style    = RX_PATTERN;
				end
			endcase
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at)
				random_item();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed tests run first, starting from the reset configuration
		test_load_extremes();
		test_cell_shapes();
		test_error_cases();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/ccbv_pkg.sv
src/ccbv_ram.sv
src/ccbv_decode.sv
src/ccbv_max.sv
src/cubical_cell_birth_value.sv
src/ccbv_checker.sv
verif/tb.sv
